// ----- rtl/rcp_pkg.sv -----
// Package for the rectangular/polar converter: widths, fixed-point constants,
// the arctangent table, the pipeline record type and shared rounding helpers.
// No dependencies.
package rcp_pkg;

   localparam int VAL_W            = 32;
   localparam int ANG_W            = 20;
   localparam int FRAC_BITS        = 16;
   localparam int GUARD            = 8;
   localparam int ANG_FRAC         = 30;
   localparam int MAX_STEPS        = 30;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int PIPE_EXTRA       = 7;

   localparam int CW = VAL_W + GUARD + 3;
   localparam int ZW = 35;

   localparam logic KIND_RECT  = 1'b0;
   localparam logic KIND_POLAR = 1'b1;

   localparam int GAIN_FRAC = 30;
   localparam int GH_W      = CW - GAIN_FRAC;
   localparam int GHP_W     = GH_W + GAIN_FRAC;
   localparam int GLP_W     = 2 * GAIN_FRAC;
   localparam logic [GAIN_FRAC-1:0] GAIN_Q30 = 30'd652032874;
   localparam logic [GLP_W:0] GAIN_RND = (GLP_W+1)'(64'd1 << (GAIN_FRAC - 1));

   localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam longint TWO_PI_Q30 = 64'sd6746518852;

   localparam int DR_W = 26;
   localparam logic signed [DR_W-1:0] DEG_TO_RAD_Q30 = 26'sd18740330;

   localparam int ANG_SHIFT = ANG_FRAC - FRAC_BITS;
   localparam longint ANG_LIM_RAW = (TWO_PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
   localparam longint ANG_W_MAX   = (64'sd1 <<< (ANG_W - 1)) - 64'sd1;
   localparam longint ANG_LIM     = (ANG_LIM_RAW > ANG_W_MAX) ? ANG_W_MAX : ANG_LIM_RAW;
   localparam logic signed [ZW-1:0] ANGLE_MAX_Z = ZW'(ANG_LIM);
   localparam logic signed [ZW-1:0] ANG_RND_Z   = ZW'(64'sd1 <<< (ANG_SHIFT - 1));

   // polar angle product: degrees times DEG_TO_RAD, then back to FRAC_BITS
   localparam int ANGP_W = VAL_W + DR_W;
   localparam logic signed [ANGP_W-1:0] ANGP_RND = ANGP_W'(64'sd1 <<< (ANG_FRAC - 1));

   // 360 degrees = 45 * 2^3, so a full turn is TURN_COUNT << RED_SHIFT
   localparam int TURN_COUNT = 45;
   localparam int REM_W      = 6;
   localparam int RED_SHIFT  = FRAC_BITS + 3;
   localparam int RED_Q_W    = VAL_W - RED_SHIFT;
   localparam int RED_U_W    = RED_Q_W + 1;
   localparam int RED_OFS    = TURN_COUNT * ((2**(RED_Q_W-1) + TURN_COUNT - 1) / TURN_COUNT);
   localparam int RECIP_K    = RED_U_W + 5;
   localparam logic [RED_U_W-1:0] RECIP = RED_U_W'((64'd1 << RECIP_K) / TURN_COUNT);
   localparam int RED_R_W    = REM_W + RED_SHIFT;
   localparam longint RED_FULL = longint'(TURN_COUNT) << RED_SHIFT;
   localparam logic [RED_R_W-1:0]        RED_HALF_R = RED_R_W'(RED_FULL >> 1);
   localparam logic signed [RED_R_W:0]   RED_FULL_S = (RED_R_W+1)'(RED_FULL);
   localparam int ZP_W = RED_R_W + 1 + DR_W;
   localparam logic signed [ZP_W-1:0] ZP_RND = ZP_W'(64'sd1 <<< (FRAC_BITS - 1));

   localparam logic [30:0] ATAN_Q30 [MAX_STEPS] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
      31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149,
      31'd1048575,   31'd524287,    31'd262143,    31'd131071,    31'd65535,
      31'd32767,     31'd16383,     31'd8191,      31'd4095,      31'd2047,
      31'd1023,      31'd511,       31'd255,       31'd127,       31'd63,
      31'd31,        31'd15,        31'd7,         31'd3,         31'd1
   };

   typedef struct packed {
      logic                    valid;
      logic                    kind;
      logic                    zero;
      logic signed [VAL_W-1:0] first;
      logic signed [VAL_W-1:0] second;
      logic signed [ANG_W-1:0] angle;
      logic signed [CW-1:0]    cx;
      logic signed [CW-1:0]    cy;
      logic signed [ZW-1:0]    z;
   } rcp_vec_type;

   function automatic logic signed [CW:0] gain_join(input logic [GHP_W-1:0] hi_p,
                                                    input logic [GLP_W-1:0] lo_p,
                                                    input logic             neg);
      logic [GLP_W:0] lo_r;
      logic [CW:0]    r;
      lo_r = {1'b0, lo_p} + GAIN_RND;
      r    = (CW+1)'(hi_p) + (CW+1)'(lo_r >> GAIN_FRAC);
      return neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [CW:0] v);
      logic signed [CW:0] t;
      t = (v + (CW+1)'(64'sd1 <<< (GUARD - 1))) >>> GUARD;
      if (t[CW:VAL_W-1] == '0 || t[CW:VAL_W-1] == '1) begin
         return t[VAL_W-1:0];
      end
      return t[CW] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
   endfunction

   function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [ZW-1:0] v);
      if (v > ANGLE_MAX_Z) begin
         return ANGLE_MAX_Z[ANG_W-1:0];
      end
      if (v < -ANGLE_MAX_Z) begin
         return ANG_W'(-ANGLE_MAX_Z);
      end
      return v[ANG_W-1:0];
   endfunction

endpackage

// ----- rtl/rcp_cordic.sv -----
// Unrolled CORDIC: one register stage per iteration, vectoring for rectangular
// items and rotation for polar items. Depends on rcp_pkg.
module rcp_cordic #(
   parameter int STEPS = rcp_pkg::DEF_CORDIC_STEPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rcp_pkg::rcp_vec_type vec_in,
   output rcp_pkg::rcp_vec_type vec_out
);
   import rcp_pkg::*;

   rcp_vec_type stage_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      rcp_vec_type          src;
      rcp_vec_type          stage_in;
      logic                 cw;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] da;

      if (i == 0) begin : g_head
         assign src = vec_in;
      end else begin : g_body
         assign src = stage_ff[i-1];
      end

      assign dx = $signed(src.cy) >>> i;
      assign dy = $signed(src.cx) >>> i;
      assign da = $signed({{(ZW-31){1'b0}}, ATAN_Q30[i]});
      assign cw = (src.kind == KIND_RECT) ? !src.cy[CW-1] : src.z[ZW-1];

      always_comb begin
         stage_in    = src;
         stage_in.cx = cw ? src.cx + dx : src.cx - dx;
         stage_in.cy = cw ? src.cy - dy : src.cy + dy;
         stage_in.z  = cw ? src.z + da : src.z - da;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[i].valid <= 1'b0;
         end else begin
            stage_ff[i] <= stage_in;
         end
      end
   end

   assign vec_out = stage_ff[STEPS-1];

endmodule

// ----- rtl/rect_polar_converter_core.sv -----
// Rectangular/polar converter top level: input preparation, CORDIC pipeline,
// gain correction and saturation. Depends on rcp_pkg and rcp_cordic.
//
// Takes one item per clock whenever busy is low and delivers its result as a
// one-cycle rsp_valid strobe; results leave in the order the items came in.
// The pipeline has one register stage per CORDIC iteration, four stages
// ahead of it (gain and angle multiplies, turn reduction, degree-to-radian
// multiply, start vector) and three after it (gain multiply, gain sum,
// rounding and saturation). Nothing in the pipeline stalls, since the
// receiver takes every result. busy is high only while reset is asserted.
module rect_polar_converter_core #(
   parameter int CORDIC_STEPS = rcp_pkg::DEF_CORDIC_STEPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic signed [rcp_pkg::VAL_W-1:0] req_first_value,
   input  logic signed [rcp_pkg::VAL_W-1:0] req_second_value,
   output logic                             rsp_valid,
   output logic signed [rcp_pkg::VAL_W-1:0] rsp_x_out,
   output logic signed [rcp_pkg::VAL_W-1:0] rsp_y_out,
   output logic signed [rcp_pkg::VAL_W-1:0] rsp_magnitude_out,
   output logic signed [rcp_pkg::ANG_W-1:0] rsp_angle_out
);
   import rcp_pkg::*;

   // stage 1: gain and angle multiplies, turn reduction multiply
   logic                      s1_valid_ff, s1_kind_ff;
   logic signed [VAL_W-1:0]   s1_first_ff, s1_second_ff;
   logic [GHP_W-1:0]          s1_ghi_ff, s1_ghi_in;
   logic [GLP_W-1:0]          s1_glo_ff, s1_glo_in;
   logic                      s1_gneg_ff;
   logic [RED_U_W-1:0]        s1_redu_ff, s1_redu_in;
   logic [2*RED_U_W-1:0]      s1_redp_ff, s1_redp_in;
   logic signed [ANGP_W-1:0]  s1_angp_ff, s1_angp_in;
   logic signed [CW-1:0]      m_ext;
   logic [CW-1:0]             m_abs;
   logic signed [RED_Q_W-1:0] red_q;

   assign m_ext = {{(CW-VAL_W-GUARD){req_first_value[VAL_W-1]}}, req_first_value,
                   {GUARD{1'b0}}};
   assign m_abs = m_ext[CW-1] ? CW'(-m_ext) : m_ext;
   assign s1_ghi_in  = m_abs[CW-1:GAIN_FRAC] * GAIN_Q30;
   assign s1_glo_in  = m_abs[GAIN_FRAC-1:0] * GAIN_Q30;
   assign red_q      = req_second_value[VAL_W-1:RED_SHIFT];
   assign s1_redu_in = {red_q[RED_Q_W-1], red_q} + RED_U_W'(RED_OFS);
   assign s1_redp_in = s1_redu_in * RECIP;
   assign s1_angp_in = req_second_value * DEG_TO_RAD_Q30;

   // stage 2: finish polar gain, turn remainder, polar angle output
   logic                       s2_valid_ff, s2_kind_ff;
   logic signed [VAL_W-1:0]    s2_first_ff, s2_second_ff;
   logic signed [CW-1:0]       s2_pcx_ff, s2_pcx_in;
   logic signed [RED_R_W:0]    s2_red_ff, s2_red_in;
   logic signed [ANG_W-1:0]    s2_ang_ff, s2_ang_in;
   logic [RED_U_W-1:0]         red_div, red_raw, red_rem;
   logic [RED_R_W-1:0]         red_pos;
   logic signed [ANGP_W-1:0]   angp_r;
   logic signed [CW:0]         pcx_full;

   assign pcx_full  = gain_join(s1_ghi_ff, s1_glo_ff, s1_gneg_ff);
   assign s2_pcx_in = pcx_full[CW-1:0];
   assign red_div   = RED_U_W'(s1_redp_ff >> RECIP_K);
   assign red_raw   = s1_redu_ff - RED_U_W'(red_div * RED_U_W'(TURN_COUNT));
   assign red_rem   = (red_raw >= RED_U_W'(TURN_COUNT)) ? red_raw - RED_U_W'(TURN_COUNT)
                                                         : red_raw;
   assign red_pos   = {red_rem[REM_W-1:0], s1_second_ff[RED_SHIFT-1:0]};
   assign s2_red_in = (red_pos > RED_HALF_R) ? $signed({1'b0, red_pos}) - RED_FULL_S
                                             : $signed({1'b0, red_pos});
   assign angp_r    = (s1_angp_ff + ANGP_RND) >>> ANG_FRAC;
   assign s2_ang_in = sat_angle(angp_r[ZW-1:0]);

   // stage 3: reduced degrees to radians
   logic                      s3_valid_ff, s3_kind_ff;
   logic signed [VAL_W-1:0]   s3_first_ff, s3_second_ff;
   logic signed [CW-1:0]      s3_pcx_ff;
   logic signed [ANG_W-1:0]   s3_ang_ff;
   logic signed [ZP_W-1:0]    s3_zprod_ff, s3_zprod_in;

   assign s3_zprod_in = s2_red_ff * DEG_TO_RAD_Q30;

   // stage 4: CORDIC start vector for either mode
   rcp_vec_type               vin_ff, vin_in, vout;
   logic signed [ZP_W-1:0]    zp_r;
   logic signed [ZW-1:0]      z_pol;
   logic                      fold_up, fold_dn;
   logic signed [CW-1:0]      a_ext, b_ext;

   assign zp_r    = (s3_zprod_ff + ZP_RND) >>> FRAC_BITS;
   assign z_pol   = zp_r[ZW-1:0];
   assign fold_up = z_pol > HALF_PI_Q30;
   assign fold_dn = z_pol < -HALF_PI_Q30;
   assign a_ext   = {{(CW-VAL_W-GUARD){s3_first_ff[VAL_W-1]}}, s3_first_ff, {GUARD{1'b0}}};
   assign b_ext   = {{(CW-VAL_W-GUARD){s3_second_ff[VAL_W-1]}}, s3_second_ff, {GUARD{1'b0}}};

   always_comb begin
      vin_in        = '0;
      vin_in.valid  = s3_valid_ff;
      vin_in.kind   = s3_kind_ff;
      vin_in.first  = s3_first_ff;
      vin_in.second = s3_second_ff;
      vin_in.angle  = s3_ang_ff;
      vin_in.zero   = (s3_kind_ff == KIND_RECT) && (s3_first_ff == '0) && (s3_second_ff == '0);
      if (s3_kind_ff == KIND_RECT) begin
         if (s3_first_ff[VAL_W-1]) begin
            vin_in.cx = -a_ext;
            vin_in.cy = -b_ext;
            vin_in.z  = s3_second_ff[VAL_W-1] ? -PI_Q30 : PI_Q30;
         end else begin
            vin_in.cx = a_ext;
            vin_in.cy = b_ext;
            vin_in.z  = '0;
         end
      end else begin
         vin_in.cy = '0;
         if (fold_up) begin
            vin_in.cx = -s3_pcx_ff;
            vin_in.z  = z_pol - PI_Q30;
         end else if (fold_dn) begin
            vin_in.cx = -s3_pcx_ff;
            vin_in.z  = z_pol + PI_Q30;
         end else begin
            vin_in.cx = s3_pcx_ff;
            vin_in.z  = z_pol;
         end
      end
   end

   rcp_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .vec_in  (vin_ff),
      .vec_out (vout)
   );

   // finish stage 1: rect angle, polar x/y, gain multiply on the rect magnitude
   logic                      e1_valid_ff, e1_kind_ff, e1_zero_ff;
   logic signed [VAL_W-1:0]   e1_first_ff, e1_x_ff, e1_x_in, e1_y_ff, e1_y_in;
   logic signed [ANG_W-1:0]   e1_ang_ff, e1_ang_in;
   logic [GHP_W-1:0]          e1_ghi_ff, e1_ghi_in;
   logic [GLP_W-1:0]          e1_glo_ff, e1_glo_in;
   logic                      e1_gneg_ff;
   logic signed [ZW-1:0]      z_rect;
   logic [CW-1:0]             c_abs;

   assign z_rect    = (vout.z + ANG_RND_Z) >>> ANG_SHIFT;
   assign e1_ang_in = (vout.kind == KIND_POLAR) ? vout.angle :
                      vout.zero ? '0 : sat_angle(z_rect);
   assign e1_x_in   = (vout.kind == KIND_POLAR) ? round_sat({vout.cx[CW-1], vout.cx})
                                                : vout.first;
   assign e1_y_in   = (vout.kind == KIND_POLAR) ? round_sat({vout.cy[CW-1], vout.cy})
                                                : vout.second;
   assign c_abs     = vout.cx[CW-1] ? CW'(-vout.cx) : vout.cx;
   assign e1_ghi_in = c_abs[CW-1:GAIN_FRAC] * GAIN_Q30;
   assign e1_glo_in = c_abs[GAIN_FRAC-1:0] * GAIN_Q30;

   // finish stage 2: gain sum
   logic                      e2_valid_ff, e2_kind_ff, e2_zero_ff;
   logic signed [VAL_W-1:0]   e2_first_ff, e2_x_ff, e2_y_ff;
   logic signed [ANG_W-1:0]   e2_ang_ff;
   logic signed [CW:0]        e2_g_ff, e2_g_in;

   assign e2_g_in = gain_join(e1_ghi_ff, e1_glo_ff, e1_gneg_ff);

   // output register
   logic                      out_valid_ff;
   logic signed [VAL_W-1:0]   out_x_ff, out_y_ff, out_mag_ff, out_mag_in;
   logic signed [ANG_W-1:0]   out_ang_ff;

   assign out_mag_in = (e2_kind_ff == KIND_POLAR) ? e2_first_ff :
                       e2_zero_ff ? '0 : round_sat(e2_g_ff);

   always_ff @(posedge clock) begin
      s1_kind_ff   <= req_kind;
      s1_first_ff  <= req_first_value;
      s1_second_ff <= req_second_value;
      s1_ghi_ff    <= s1_ghi_in;
      s1_glo_ff    <= s1_glo_in;
      s1_gneg_ff   <= m_ext[CW-1];
      s1_redu_ff   <= s1_redu_in;
      s1_redp_ff   <= s1_redp_in;
      s1_angp_ff   <= s1_angp_in;

      s2_kind_ff   <= s1_kind_ff;
      s2_first_ff  <= s1_first_ff;
      s2_second_ff <= s1_second_ff;
      s2_pcx_ff    <= s2_pcx_in;
      s2_red_ff    <= s2_red_in;
      s2_ang_ff    <= s2_ang_in;

      s3_kind_ff   <= s2_kind_ff;
      s3_first_ff  <= s2_first_ff;
      s3_second_ff <= s2_second_ff;
      s3_pcx_ff    <= s2_pcx_ff;
      s3_ang_ff    <= s2_ang_ff;
      s3_zprod_ff  <= s3_zprod_in;

      e1_kind_ff   <= vout.kind;
      e1_zero_ff   <= vout.zero;
      e1_first_ff  <= vout.first;
      e1_x_ff      <= e1_x_in;
      e1_y_ff      <= e1_y_in;
      e1_ang_ff    <= e1_ang_in;
      e1_ghi_ff    <= e1_ghi_in;
      e1_glo_ff    <= e1_glo_in;
      e1_gneg_ff   <= vout.cx[CW-1];

      e2_kind_ff   <= e1_kind_ff;
      e2_zero_ff   <= e1_zero_ff;
      e2_first_ff  <= e1_first_ff;
      e2_x_ff      <= e1_x_ff;
      e2_y_ff      <= e1_y_ff;
      e2_ang_ff    <= e1_ang_ff;
      e2_g_ff      <= e2_g_in;

      out_x_ff     <= e2_x_ff;
      out_y_ff     <= e2_y_ff;
      out_mag_ff   <= out_mag_in;
      out_ang_ff   <= e2_ang_ff;

      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         vin_ff.valid <= 1'b0;
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         vin_ff       <= vin_in;
         e1_valid_ff  <= vout.valid;
         e2_valid_ff  <= e1_valid_ff;
         out_valid_ff <= e2_valid_ff;
      end
   end

   assign busy              = reset;
   assign rsp_valid         = out_valid_ff;
   assign rsp_x_out         = out_x_ff;
   assign rsp_y_out         = out_y_ff;
   assign rsp_magnitude_out = out_mag_ff;
   assign rsp_angle_out     = out_ang_ff;

endmodule

// ----- rtl/rcp_checker.sv -----
// Port-level checks for the rectangular/polar converter, bound to its top level.
// Depends on rcp_pkg.
module rcp_checker #(
   parameter int CORDIC_STEPS = rcp_pkg::DEF_CORDIC_STEPS
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_kind,
   input logic signed [rcp_pkg::VAL_W-1:0] req_first_value,
   input logic signed [rcp_pkg::VAL_W-1:0] req_second_value,
   input logic                             rsp_valid,
   input logic signed [rcp_pkg::VAL_W-1:0] rsp_x_out,
   input logic signed [rcp_pkg::VAL_W-1:0] rsp_y_out,
   input logic signed [rcp_pkg::VAL_W-1:0] rsp_magnitude_out,
   input logic signed [rcp_pkg::ANG_W-1:0] rsp_angle_out
);
   import rcp_pkg::*;

   localparam int LATENCY = CORDIC_STEPS + PIPE_EXTRA;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transfer without result after fixed latency");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without matching transfer");

   a_rect_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_RECT) |-> ##LATENCY
         (rsp_x_out == $past(req_first_value, LATENCY) &&
          rsp_y_out == $past(req_second_value, LATENCY)))
      else $error("rectangular x/y not passed through");

   a_rect_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_RECT && req_first_value == '0 &&
       req_second_value == '0) |-> ##LATENCY
         (rsp_magnitude_out == '0 && rsp_angle_out == '0))
      else $error("zero vector gave nonzero magnitude or angle");

endmodule

bind rect_polar_converter_core rcp_checker #(
   .CORDIC_STEPS (CORDIC_STEPS)
) u_rcp_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_kind          (req_kind),
   .req_first_value   (req_first_value),
   .req_second_value  (req_second_value),
   .rsp_valid         (rsp_valid),
   .rsp_x_out         (rsp_x_out),
   .rsp_y_out         (rsp_y_out),
   .rsp_magnitude_out (rsp_magnitude_out),
   .rsp_angle_out     (rsp_angle_out)
);
